// ===== rtl/rrbt_pkg.sv =====
// Package for the round-robin register binding table.
// Holds the request codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package rrbt_pkg;

    // Field widths fixed by the request and result formats.
    localparam int FUNC_W  = 4;
    localparam int KEY_W   = 32;
    localparam int PIDX_W  = 3;
    localparam int REG_W   = 5;
    localparam int SLOT_W  = 4;

    // Parameter defaults.
    localparam int NUM_REGS_DEF  = 15;
    localparam int STACK_REG_DEF = 16;
    localparam int LINK_REG_DEF  = 17;

    // Reset value of the return register setting.
    localparam logic [SLOT_W-1:0] RET_REG_RESET = 4'd8;

    // Request codes. Codes 9 through 15 carry no meaning and act as zero.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_VALUE     = 4'd0,
        FUNC_RETURN    = 4'd1,
        FUNC_PARAM     = 4'd2,
        FUNC_IMMEDIATE = 4'd3,
        FUNC_STACK     = 4'd4,
        FUNC_LINK      = 4'd5,
        FUNC_ZERO      = 4'd6,
        FUNC_CLEAR     = 4'd7,
        FUNC_PROBE     = 4'd8
    } func_t;

endpackage

// ===== rtl/round_robin_register_binding_table.sv =====
// Round-robin register binding table: a fully associative table of slots
// with a parallel key compare and a round-robin replacement pointer.
//
// Usage:
//   Requests arrive as beats on the s_axis channel: tuser carries the
//   request code, tdata carries the key and the parameter index. Each
//   request yields exactly one result beat on m_axis: tdata carries the
//   granted or found register number, tuser carries the hit flag.
//   The return register setting is written through cfg_wdata when cfg_we is
//   set; the user must write it only while no request is in flight, as the block does not enforce it.
//   An accepted request beat passes through the input register and then
//   the result register to its result beat. One request beat is taken
//   every cycle while m_axis takes results; the limit is the compare of
//   the key against every slot together with the table and pointer update,
//   which sits between the input register and the result register.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat, after which s_axis_tready drops until m_axis moves.
//   Reset empties the table, sets the pointer to slot one and the return
//   register to eight. Stored keys are not cleared; they are only used
//   while their slot is valid.
`timescale 1ns / 1ps

module round_robin_register_binding_table #(
    parameter int NUM_REGS  = rrbt_pkg::NUM_REGS_DEF,
    parameter int STACK_REG = rrbt_pkg::STACK_REG_DEF,
    parameter int LINK_REG  = rrbt_pkg::LINK_REG_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write: return register slot number.
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,

    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] key, [34:32] param_index, [39:35] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] func

    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] reg_number, [7:5] zero
    output logic [0:0]  m_axis_tuser    // [0] hit
);

    localparam int IDX_W = $clog2(NUM_REGS);

    localparam int REG_W  = rrbt_pkg::REG_W;
    localparam int SLOT_W = rrbt_pkg::SLOT_W;
    localparam int KEY_W  = rrbt_pkg::KEY_W;
    localparam int PIDX_W = rrbt_pkg::PIDX_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_REGS);
    localparam logic [REG_W-1:0]  LAST_REG  = REG_W'(NUM_REGS);

    // Input register.
    logic                in_valid_reg;
    rrbt_pkg::func_t     in_func_reg;
    logic [KEY_W-1:0]    in_key_reg;
    logic [PIDX_W-1:0]   in_pidx_reg;

    // Result register.
    logic                out_valid_reg;
    logic [REG_W-1:0]    out_reg_num_reg;
    logic                out_hit_reg;
    logic [REG_W-1:0]    out_reg_num_next;
    logic                out_hit_next;

    // Table state and setting.
    logic [KEY_W-1:0]    slot_key_reg [NUM_REGS];
    logic [NUM_REGS-1:0] slot_valid_reg;
    logic [NUM_REGS-1:0] slot_valid_next;
    logic [SLOT_W-1:0]   next_slot_reg;
    logic [SLOT_W-1:0]   next_slot_next;
    logic [SLOT_W-1:0]   ret_reg_reg;

    logic                key_we;
    logic [IDX_W-1:0]    key_idx;

    logic                advance;
    logic                match_hit;
    logic [SLOT_W-1:0]   match_slot;
    logic [SLOT_W-1:0]   rr_slot_after;
    logic [REG_W-1:0]    fixed_reg;
    logic                fixed_in_table;

    // Handshake: the item in the input register moves on when the result
    // register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg_num_reg};
    assign m_axis_tuser  = out_hit_reg;

    // Parallel key compare; the lowest matching slot wins.
    always_comb
    begin
        match_hit  = 1'b0;
        match_slot = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_key_reg[i] == in_key_reg))
            begin
                match_hit  = 1'b1;
                match_slot = SLOT_W'(i + 1);
            end
        end
    end

    // Pointer value after taking the round-robin slot.
    assign rr_slot_after = (next_slot_reg == LAST_SLOT) ? SLOT_W'(1)
                                                        : next_slot_reg + SLOT_W'(1);

    // Fixed slot named by return and parameter requests.
    always_comb
    begin
        if (in_func_reg == rrbt_pkg::FUNC_PARAM)
            fixed_reg = {1'b0, ret_reg_reg} + {{(REG_W-PIDX_W){1'b0}}, in_pidx_reg};
        else
            fixed_reg = {1'b0, ret_reg_reg};
    end
    assign fixed_in_table = (fixed_reg != '0) && (fixed_reg <= LAST_REG);

    // Request decode, table update and result.
    always_comb
    begin
        slot_valid_next  = slot_valid_reg;
        next_slot_next   = next_slot_reg;
        key_we           = 1'b0;
        key_idx          = IDX_W'(next_slot_reg - SLOT_W'(1));
        out_reg_num_next = '0;
        out_hit_next     = 1'b0;
        unique case (in_func_reg)
            rrbt_pkg::FUNC_VALUE:
            begin
                if (match_hit)
                begin
                    out_reg_num_next = {1'b0, match_slot};
                    out_hit_next     = 1'b1;
                end
                else
                begin
                    out_reg_num_next          = {1'b0, next_slot_reg};
                    next_slot_next            = rr_slot_after;
                    slot_valid_next[key_idx]  = 1'b1;
                    key_we                    = 1'b1;
                end
            end
            rrbt_pkg::FUNC_RETURN,
            rrbt_pkg::FUNC_PARAM:
            begin
                out_reg_num_next = fixed_reg;
                if (fixed_in_table)
                    slot_valid_next[IDX_W'(fixed_reg - REG_W'(1))] = 1'b0;
            end
            rrbt_pkg::FUNC_IMMEDIATE:
            begin
                out_reg_num_next         = {1'b0, next_slot_reg};
                next_slot_next           = rr_slot_after;
                slot_valid_next[key_idx] = 1'b0;
            end
            rrbt_pkg::FUNC_STACK:
                out_reg_num_next = REG_W'(STACK_REG);
            rrbt_pkg::FUNC_LINK:
                out_reg_num_next = REG_W'(LINK_REG);
            rrbt_pkg::FUNC_CLEAR:
            begin
                slot_valid_next = '0;
                next_slot_next  = SLOT_W'(1);
            end
            rrbt_pkg::FUNC_PROBE:
            begin
                out_reg_num_next = {1'b0, match_slot};
                out_hit_next     = match_hit;
            end
            default:
                out_reg_num_next = '0;
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_func_reg <= rrbt_pkg::func_t'(s_axis_tuser);
            in_key_reg  <= s_axis_tdata[KEY_W-1:0];
            in_pidx_reg <= s_axis_tdata[KEY_W+PIDX_W-1:KEY_W];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg_num_reg <= out_reg_num_next;
            out_hit_reg     <= out_hit_next;
        end
    end

    // Table control state and the return register setting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            next_slot_reg  <= SLOT_W'(1);
            ret_reg_reg    <= rrbt_pkg::RET_REG_RESET;
        end
        else
        begin
            if (advance)
            begin
                slot_valid_reg <= slot_valid_next;
                next_slot_reg  <= next_slot_next;
            end
            if (cfg_we)
                ret_reg_reg <= cfg_wdata;
        end
    end

    // Stored keys.
    always_ff @(posedge clk)
    begin
        if (advance && key_we)
            slot_key_reg[key_idx] <= in_key_reg;
    end

    // The round-robin pointer always names a slot of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_slot_reg != '0) && (next_slot_reg <= LAST_SLOT))
        else $error("round-robin pointer out of range");

    // A clear leaves an empty table with the pointer at slot one.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == rrbt_pkg::FUNC_CLEAR)
        |=> (slot_valid_reg == '0) && (next_slot_reg == SLOT_W'(1)))
        else $error("clear did not empty the table");

    // Only value and probe requests may report a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg != rrbt_pkg::FUNC_VALUE)
                && (in_func_reg != rrbt_pkg::FUNC_PROBE)
        |=> !out_hit_reg)
        else $error("hit reported for a request without lookup");

    // A value request leaves its slot bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_func_reg == rrbt_pkg::FUNC_VALUE)
        |=> (slot_valid_reg != '0))
        else $error("value request left the table empty");

endmodule
